[sv/ncp_pkg.sv]
// Shared types and constants for the nested category cycle profiler.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package ncp_pkg;

   localparam int MODE_W  = 2;
   localparam int CAT_W   = 4;
   localparam int TS_W    = 64;
   localparam int DEPTH_W = 4;
   localparam int STAT_W  = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_BEGIN = 2'd0,
      MODE_END   = 2'd1,
      MODE_READ  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_DISABLED  = 3'd1,
      STAT_RANGE     = 3'd2,
      STAT_UNMATCHED = 3'd3,
      STAT_FULL      = 3'd4
   } status_type;

   // Stack update request for one word.
   typedef struct packed {
      logic             push;
      logic             pop;
      logic             clear;
      logic [CAT_W-1:0] cat;
   } stk_ctrl_type;

   // Totals bank request for one word.
   typedef struct packed {
      logic             add;
      logic             clear;
      logic [CAT_W-1:0] addr;
   } tot_ctrl_type;

endpackage

`default_nettype wire

[sv/ncp_if.sv]
// Valid/ready channel interfaces for the profiler's event and result words.
// Depends on ncp_pkg for field widths.
`default_nettype none

interface ncp_req_if;
   logic                     valid;
   logic                     ready;
   logic [ncp_pkg::MODE_W-1:0] mode;
   logic [ncp_pkg::CAT_W-1:0]  category;
   logic [ncp_pkg::TS_W-1:0]   timestamp;

   modport source (output valid, output mode, output category, output timestamp,
                   input ready);
   modport sink   (input valid, input mode, input category, input timestamp,
                   output ready);
endinterface

interface ncp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        credit_valid;
   logic [ncp_pkg::CAT_W-1:0]   credited_category;
   logic [ncp_pkg::TS_W-1:0]    credited_amount;
   logic [ncp_pkg::TS_W-1:0]    category_total;
   logic [ncp_pkg::DEPTH_W-1:0] stack_depth_now;
   logic [ncp_pkg::STAT_W-1:0]  status;

   modport source (output valid, output credit_valid, output credited_category,
                   output credited_amount, output category_total,
                   output stack_depth_now, output status, input ready);
   modport sink   (input valid, input credit_valid, input credited_category,
                   input credited_amount, input category_total,
                   input stack_depth_now, input status, output ready);
endinterface

`default_nettype wire

[sv/ncp_stack.sv]
// Stack of open categories with its depth counter.
// Depends on ncp_pkg.
`default_nettype none

module ncp_stack #(
   parameter int MAX_DEPTH = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ncp_pkg::stk_ctrl_type       ctrl,
   output logic [ncp_pkg::DEPTH_W-1:0]      depth,
   output logic [ncp_pkg::CAT_W-1:0]        top_cat
);
   import ncp_pkg::*;

   localparam int SP_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [CAT_W-1:0]   stack_ff [MAX_DEPTH];
   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] depth_in;
   logic [DEPTH_W-1:0] top_pos;

   assign top_pos = depth_ff - DEPTH_W'(1);
   assign top_cat = stack_ff[top_pos[SP_W-1:0]];
   assign depth   = depth_ff;

   always_comb begin
      depth_in = depth_ff;
      if (ctrl.clear) begin
         depth_in = '0;
      end else if (ctrl.push) begin
         depth_in = depth_ff + DEPTH_W'(1);
      end else if (ctrl.pop) begin
         depth_in = depth_ff - DEPTH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // Entries carry no reset; only slots below the depth are ever used.
   always_ff @(posedge clock) begin
      if (ctrl.push && !ctrl.clear) begin
         stack_ff[depth_ff[SP_W-1:0]] <= ctrl.cat;
      end
   end

endmodule

`default_nettype wire

[sv/ncp_totals.sv]
// Per-category 64-bit cycle totals with one read port and an adder.
// Depends on ncp_pkg.
`default_nettype none

module ncp_totals #(
   parameter int NUM_CATEGORIES = 9
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ncp_pkg::tot_ctrl_type    ctrl,
   input  wire logic [ncp_pkg::TS_W-1:0] amount,
   output logic [ncp_pkg::TS_W-1:0]      rd_total,
   output logic [ncp_pkg::TS_W-1:0]      sum
);
   import ncp_pkg::*;

   localparam int IDX_W = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;

   logic [TS_W-1:0] totals_ff [NUM_CATEGORIES];

   assign rd_total = totals_ff[ctrl.addr[IDX_W-1:0]];
   assign sum      = rd_total + amount;

   // Clear wipes every total; totals wrap modulo 2^64.
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int i = 0; i < NUM_CATEGORIES; i++) begin
            totals_ff[i] <= '0;
         end
      end else if (ctrl.add) begin
         totals_ff[ctrl.addr[IDX_W-1:0]] <= sum;
      end
   end

endmodule

`default_nettype wire

[sv/nested_category_cycle_profiler.sv]
// Top level of the exclusive-time category profiler.
// Depends on ncp_pkg, ncp_if, ncp_stack and ncp_totals.
`default_nettype none

// Exclusive-time profiler. Each event word carries a mode (begin, end, read,
// clear), a category and a 64-bit timestamp; every event word yields exactly
// one result word. The block accepts one event word per clock while the
// result register is free or being drained. The word is held in the input
// register, then one pass through the credit logic (a 64-bit subtract of the
// segment start, then a 64-bit add into the category total) loads the
// result register that presents it.
// Stack, totals and segment start are updated on that same pass, so the next
// word sees them at once. A held result stalls the pipe, but one more event
// word is still taken into the input register.
// Begin/end with enable low, begin with a category outside NUM_CATEGORIES
// and end on an empty stack change nothing and are flagged in status; a
// begin on a full stack credits and restarts the segment without pushing.
// Read and clear act regardless of enable. csr_wr_en/csr_wr_data write the
// enable bit (reset value 1); write it only while the block is idle.
module nested_category_cycle_profiler #(
   parameter int NUM_CATEGORIES = 9,
   parameter int MAX_DEPTH      = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   ncp_req_if.sink   req_chan,
   ncp_rsp_if.source rsp_chan,
   input  wire logic csr_wr_en,
   input  wire logic csr_wr_data
);
   import ncp_pkg::*;

   // enable register
   logic enable_ff;

   // input register
   logic             s1_valid_ff;
   mode_type         s1_mode_ff;
   logic [CAT_W-1:0] s1_cat_ff;
   logic [TS_W-1:0]  s1_ts_ff;

   // segment start
   logic [TS_W-1:0] seg_ff;
   logic [TS_W-1:0] seg_in;

   // result register
   logic               out_valid_ff;
   logic               out_credit_ff;
   logic [CAT_W-1:0]   out_cat_ff;
   logic [TS_W-1:0]    out_amount_ff;
   logic [TS_W-1:0]    out_total_ff;
   logic [DEPTH_W-1:0] out_depth_ff;
   status_type         out_status_ff;

   // pass logic
   logic               advance;
   logic               fire;
   logic               stack_empty;
   logic               stack_full;
   logic               cat_ok;
   logic               credit;
   logic [CAT_W-1:0]   res_cat;
   logic [TS_W-1:0]    res_total;
   logic [DEPTH_W-1:0] depth_after;
   logic [TS_W-1:0]    amount;
   status_type         status;
   stk_ctrl_type       stk_ctrl;
   tot_ctrl_type       tot_ctrl;
   logic [DEPTH_W-1:0] depth;
   logic [CAT_W-1:0]   top_cat;
   logic [TS_W-1:0]    rd_total;
   logic [TS_W-1:0]    sum;

   // advance the pipe when the result register is free or being drained
   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign fire           = s1_valid_ff && advance;
   assign req_chan.ready = !s1_valid_ff || advance;

   assign stack_empty = (depth == '0);
   assign stack_full  = (depth == DEPTH_W'(MAX_DEPTH));
   assign cat_ok      = ({1'b0, s1_cat_ff} < (CAT_W + 1)'(NUM_CATEGORIES));
   assign amount      = s1_ts_ff - seg_ff;

   ncp_stack #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (stk_ctrl),
      .depth   (depth),
      .top_cat (top_cat)
   );

   ncp_totals #(
      .NUM_CATEGORIES (NUM_CATEGORIES)
   ) u_totals (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (tot_ctrl),
      .amount   (amount),
      .rd_total (rd_total),
      .sum      (sum)
   );

   // Decode the held word; state only moves when it fires.
   always_comb begin
      credit         = 1'b0;
      status         = STAT_OK;
      seg_in         = seg_ff;
      stk_ctrl       = '0;
      stk_ctrl.cat   = s1_cat_ff;
      tot_ctrl       = '0;
      tot_ctrl.addr  = top_cat;
      res_cat        = '0;
      res_total      = '0;
      depth_after    = depth;
      unique case (s1_mode_ff)
         MODE_BEGIN: begin
            if (!enable_ff) begin
               status = STAT_DISABLED;
            end else if (!cat_ok) begin
               status = STAT_RANGE;
            end else begin
               credit        = !stack_empty;
               stk_ctrl.push = !stack_full;
               seg_in        = s1_ts_ff;
               if (stack_full) begin
                  status = STAT_FULL;
               end else begin
                  depth_after = depth + DEPTH_W'(1);
               end
            end
         end
         MODE_END: begin
            if (!enable_ff) begin
               status = STAT_DISABLED;
            end else if (stack_empty) begin
               status = STAT_UNMATCHED;
            end else begin
               credit       = 1'b1;
               stk_ctrl.pop = 1'b1;
               seg_in       = s1_ts_ff;
               depth_after  = depth - DEPTH_W'(1);
            end
         end
         MODE_READ: begin
            tot_ctrl.addr = s1_cat_ff;
            res_cat       = s1_cat_ff;
            if (cat_ok) begin
               res_total = rd_total;
            end else begin
               status = STAT_RANGE;
            end
         end
         MODE_CLEAR: begin
            stk_ctrl.clear = 1'b1;
            tot_ctrl.clear = 1'b1;
            seg_in         = '0;
            depth_after    = '0;
         end
      endcase
      if (credit) begin
         tot_ctrl.add = 1'b1;
         res_cat      = top_cat;
         res_total    = sum;
      end
      // drop every state change unless the word fires this cycle
      if (!fire) begin
         stk_ctrl.push  = 1'b0;
         stk_ctrl.pop   = 1'b0;
         stk_ctrl.clear = 1'b0;
         tot_ctrl.add   = 1'b0;
         tot_ctrl.clear = 1'b0;
         seg_in         = seg_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seg_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
         seg_ff <= seg_in;
      end
   end

   // input payload: hold while the pipe is stalled
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_mode_ff <= mode_type'(req_chan.mode);
         s1_cat_ff  <= req_chan.category;
         s1_ts_ff   <= req_chan.timestamp;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fire) begin
         out_credit_ff <= credit;
         out_cat_ff    <= res_cat;
         out_amount_ff <= credit ? amount : '0;
         out_total_ff  <= res_total;
         out_depth_ff  <= depth_after;
         out_status_ff <= status;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.credit_valid      = out_credit_ff;
   assign rsp_chan.credited_category = out_cat_ff;
   assign rsp_chan.credited_amount   = out_amount_ff;
   assign rsp_chan.category_total    = out_total_ff;
   assign rsp_chan.stack_depth_now   = out_depth_ff;
   assign rsp_chan.status            = out_status_ff;

endmodule

`default_nettype wire

[sv/ncp_checker.sv]
// Port-level checks for the profiler, bound to the top level.
// Depends on ncp_pkg and the top level's ports.
`default_nettype none

module ncp_checker #(
   parameter int MAX_DEPTH = 8
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        credit_valid,
   input wire logic [ncp_pkg::TS_W-1:0]    credited_amount,
   input wire logic [ncp_pkg::DEPTH_W-1:0] stack_depth_now,
   input wire logic [ncp_pkg::STAT_W-1:0]  status
);
   import ncp_pkg::*;

   // a result word waiting for the sink holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
         && $stable(credited_amount) && $stable(stack_depth_now))
      else $error("result word changed while stalled");

   // no result word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word presented after reset");

   // credit only on accepted begin/end
   a_credit_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && credit_valid |-> (status == STAT_OK || status == STAT_FULL))
      else $error("credit reported with an ignore status");

   // no credit means no amount
   a_no_credit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !credit_valid |-> credited_amount == '0)
      else $error("amount reported without credit");

   // stack full status only at full depth
   a_full_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == STAT_FULL |-> stack_depth_now == DEPTH_W'(MAX_DEPTH))
      else $error("stack full reported below full depth");

endmodule

bind nested_category_cycle_profiler ncp_checker #(
   .MAX_DEPTH (MAX_DEPTH)
) u_ncp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .credit_valid    (rsp_chan.credit_valid),
   .credited_amount (rsp_chan.credited_amount),
   .stack_depth_now (rsp_chan.stack_depth_now),
   .status          (rsp_chan.status)
);

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for nested_category_cycle_profiler: event words in, result words out.
// Depends on ncp_pkg and the channel interfaces in ncp_if; predicts every result word in line.

module tb;
   import ncp_pkg::*;

   localparam int NUM_CATS     = 9;
   localparam int MAX_OPEN     = 8;
   localparam int IDLE_PCT     = 12;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   // One result word as the block should present it.
   typedef struct packed {
      logic               credit_valid;
      logic [CAT_W-1:0]   cat;
      logic [TS_W-1:0]    amount;
      logic [TS_W-1:0]    total;
      logic [DEPTH_W-1:0] depth;
      status_type         status;
   } profile_word_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   ncp_req_if req_bus ();
   ncp_rsp_if rsp_bus ();

   nested_category_cycle_profiler #(
      .NUM_CATEGORIES (NUM_CATS),
      .MAX_DEPTH      (MAX_OPEN)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   // Profiler state as the testbench sees it.
   logic [TS_W-1:0]  prof_totals [NUM_CATS];
   logic [CAT_W-1:0] prof_stack [MAX_OPEN];
   int               prof_depth;
   logic [TS_W-1:0]  prof_seg_start;
   bit               prof_on;

   profile_word_type pending_profiles [$];

   bit no_idle = 1'b0;
   int fail_count = 0;
   int events_sent = 0;
   int words_checked = 0;
   int credits_seen = 0;
   int full_hits = 0;
   int ignored_events = 0;
   int enable_writes = 0;
   int idle_cycles = 0;
   logic [TS_W-1:0] ts_cursor = '0;

   // Credit the innermost open category with the time since the segment start.
   function automatic void credit_innermost(input logic [TS_W-1:0] now,
                                            inout profile_word_type w);
      logic [CAT_W-1:0] top;
      logic [TS_W-1:0]  amt;
      top = prof_stack[prof_depth - 1];
      amt = now - prof_seg_start;
      prof_totals[top] = prof_totals[top] + amt;
      w.credit_valid = 1'b1;
      w.cat          = top;
      w.amount       = amt;
      w.total        = prof_totals[top];
   endfunction

   // Advance the profiler state by one event word and return its result word.
   function automatic profile_word_type profile_event(input mode_type mode,
                                                      input logic [CAT_W-1:0] cat,
                                                      input logic [TS_W-1:0] now);
      profile_word_type w;
      w = '0;
      w.status = STAT_OK;
      case (mode)
         MODE_BEGIN: begin
            if (!prof_on) begin
               w.status = STAT_DISABLED;
            end else if (cat >= NUM_CATS) begin
               w.status = STAT_RANGE;
            end else begin
               if (prof_depth > 0) credit_innermost(now, w);
               if (prof_depth < MAX_OPEN) begin
                  prof_stack[prof_depth] = cat;
                  prof_depth++;
               end else begin
                  w.status = STAT_FULL;
               end
               prof_seg_start = now;
            end
         end
         MODE_END: begin
            if (!prof_on) begin
               w.status = STAT_DISABLED;
            end else if (prof_depth == 0) begin
               w.status = STAT_UNMATCHED;
            end else begin
               credit_innermost(now, w);
               prof_depth--;
               prof_seg_start = now;
            end
         end
         MODE_READ: begin
            w.cat = cat;
            if (cat < NUM_CATS) w.total = prof_totals[cat];
            else w.status = STAT_RANGE;
         end
         default: begin
            foreach (prof_totals[i]) prof_totals[i] = '0;
            prof_depth     = 0;
            prof_seg_start = '0;
         end
      endcase
      w.depth = DEPTH_W'(prof_depth);
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [TS_W-1:0] got,
                                  input logic [TS_W-1:0] want);
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Offer one event word, with a random gap first, and hold it until taken.
   task automatic send_event(input mode_type mode, input logic [CAT_W-1:0] cat,
                             input logic [TS_W-1:0] ts);
      profile_word_type w;
      if (!no_idle) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid     <= 1'b1;
      req_bus.mode      <= mode;
      req_bus.category  <= cat;
      req_bus.timestamp <= ts;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      w = profile_event(mode, cat, ts);
      pending_profiles.push_back(w);
      events_sent++;
      if (w.credit_valid) credits_seen++;
      if (w.status == STAT_FULL) full_hits++;
      if (w.status inside {STAT_DISABLED, STAT_UNMATCHED} ||
          (w.status == STAT_RANGE && mode == MODE_BEGIN))
         ignored_events++;
   endtask

   // Drop valid and hold until every result word is back and the pipe is quiet.
   task automatic drain_pipeline();
      req_bus.valid <= 1'b0;
      while (pending_profiles.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write the enable bit; call only with the block drained.
   task automatic set_enable(input bit value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      prof_on = value;
      enable_writes++;
   endtask

   // Nest to full depth, overflow the stack, and wrap the timestamp.
   task automatic test_nesting_and_wrap();
      send_event(MODE_END,   4'd0,  64'd0);      // end with nothing open
      send_event(MODE_BEGIN, 4'd0,  64'd10);     // first begin credits nobody
      send_event(MODE_BEGIN, 4'hF,  64'd20);     // category out of range
      send_event(MODE_BEGIN, 4'd8,  64'd110);    // highest legal category
      for (int c = 1; c <= 6; c++)
         send_event(MODE_BEGIN, CAT_W'(c), 64'(100 * c + 200));
      send_event(MODE_BEGIN, 4'd7,  64'd1500);   // stack full: credit, no push
      send_event(MODE_END,   4'd0,  '1);         // largest timestamp
      send_event(MODE_BEGIN, 4'd3,  64'd0);      // amount wraps around zero
   endtask

   // Read legal and illegal categories, then clear everything and check the emptied state.
   task automatic test_read_and_clear();
      send_event(MODE_READ,  4'd5,  64'd7);
      send_event(MODE_READ,  4'd9,  64'd7);
      send_event(MODE_READ,  4'hF,  '1);
      send_event(MODE_READ,  4'd8,  64'd7);
      send_event(MODE_CLEAR, 4'hA,  64'd9);
      send_event(MODE_READ,  4'd5,  64'd9);
      send_event(MODE_END,   4'd0,  64'd12);
      send_event(MODE_BEGIN, 4'd4,  64'd50);
   endtask

   // With enable low, begin and end are ignored; read and clear still act.
   task automatic test_disabled();
      drain_pipeline();
      set_enable(1'b0);
      send_event(MODE_BEGIN, 4'd2,  64'd60);
      send_event(MODE_END,   4'd0,  64'd70);
      send_event(MODE_READ,  4'd4,  64'd80);
      send_event(MODE_CLEAR, 4'd0,  64'd90);
      drain_pipeline();
      set_enable(1'b1);
   endtask

   // Random nesting traffic; begin_pct steers how deep the stack tends to sit.
   task automatic random_phase(input int n_items, input int begin_pct);
      int               roll;
      int               jump;
      mode_type         mode;
      logic [CAT_W-1:0] cat;
      for (int i = 0; i < n_items; i++) begin
         jump = $urandom_range(0, 99);
         if (jump < 85) ts_cursor = ts_cursor + $urandom_range(0, 40);
         else if (jump < 97) ts_cursor = ts_cursor + {32'd0, $urandom};
         else ts_cursor = {$urandom, $urandom};
         roll = $urandom_range(0, 99);
         if (roll < begin_pct) begin
            mode = MODE_BEGIN;
            if ($urandom_range(0, 15) < 2) cat = CAT_W'($urandom_range(0, 15));
            else cat = CAT_W'($urandom_range(0, NUM_CATS - 1));
         end else if (roll < 88) begin
            mode = MODE_END;
            cat  = CAT_W'($urandom_range(0, 15));
         end else if (roll < 98) begin
            mode = MODE_READ;
            cat  = CAT_W'($urandom_range(0, 15));
         end else begin
            mode = MODE_CLEAR;
            cat  = CAT_W'($urandom_range(0, 15));
         end
         send_event(mode, cat, ts_cursor);
      end
   endtask

   // One long stretch at full rate, then phases of varying depth with short
   // disabled stretches in between.
   task automatic test_random_traffic();
      no_idle = 1'b1;
      random_phase(250, 50);
      no_idle = 1'b0;
      for (int p = 0; p < 7; p++) begin
         random_phase(200, 40 + 5 * p);
         drain_pipeline();
         set_enable(1'b0);
         random_phase(15, 50);
         drain_pipeline();
         set_enable(1'b1);
      end
   endtask

   // Check each accepted result word against the oldest expectation, then
   // pick the stall for the next cycle.
   always @(posedge clock) begin
      profile_word_type w;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_profiles.size() == 0) begin
            report_mismatch("result word with nothing expected", 64'(rsp_bus.status), '0);
         end else begin
            w = pending_profiles.pop_front();
            words_checked++;
            if (rsp_bus.credit_valid !== w.credit_valid)
               report_mismatch("credit_valid", 64'(rsp_bus.credit_valid), 64'(w.credit_valid));
            if (rsp_bus.credited_category !== w.cat)
               report_mismatch("credited_category", 64'(rsp_bus.credited_category), 64'(w.cat));
            if (rsp_bus.credited_amount !== w.amount)
               report_mismatch("credited_amount", rsp_bus.credited_amount, w.amount);
            if (rsp_bus.category_total !== w.total)
               report_mismatch("category_total", rsp_bus.category_total, w.total);
            if (rsp_bus.stack_depth_now !== w.depth)
               report_mismatch("stack_depth_now", 64'(rsp_bus.stack_depth_now), 64'(w.depth));
            if (rsp_bus.status !== w.status)
               report_mismatch("status", 64'(rsp_bus.status), 64'(w.status));
         end
      end
      rsp_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Abort when neither channel has moved a word for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_profiles.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = 1'b0;
      req_bus.valid     = 1'b0;
      req_bus.mode      = MODE_BEGIN;
      req_bus.category  = '0;
      req_bus.timestamp = '0;
      rsp_bus.ready     = 1'b0;
      foreach (prof_totals[i]) prof_totals[i] = '0;
      foreach (prof_stack[i]) prof_stack[i] = '0;
      prof_depth     = 0;
      prof_seg_start = '0;
      prof_on        = 1'b1;

      // Hold reset, then release it for good.
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_nesting_and_wrap();
      test_read_and_clear();
      test_disabled();
      test_random_traffic();

      drain_pipeline();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d event words and %0d result words over %0d enable writes:",
               events_sent, words_checked, enable_writes);
      $display("  %0d credits, %0d stack-full begins, %0d ignored events, %0d mismatches",
               credits_seen, full_hits, ignored_events, fail_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
